// ----- rtl/sm83_pkg.sv -----
// sm83_pkg: operation codes, flag layout and bundle types for the sm83 byte alu
// no dependencies; imported by the alu core, the top level and the checker
`timescale 1ns / 1ps

package sm83_pkg;

   localparam int unsigned DataWidth = 8;
   localparam int unsigned OpWidth   = 5;
   localparam int unsigned BitIdxWidth = 3;
   localparam int unsigned FlagWidth = 4;

   // decimal adjust constants
   localparam logic [3:0] BcdLowMax  = 4'h9;
   localparam logic [7:0] BcdByteMax = 8'h99;
   localparam logic [3:0] BcdCorr    = 4'h6;

   typedef enum logic [OpWidth-1:0] {
      OP_ADD  = 5'd0,
      OP_ADC  = 5'd1,
      OP_SUB  = 5'd2,
      OP_SBC  = 5'd3,
      OP_AND  = 5'd4,
      OP_XOR  = 5'd5,
      OP_OR   = 5'd6,
      OP_CP   = 5'd7,
      OP_INC  = 5'd8,
      OP_DEC  = 5'd9,
      OP_DAA  = 5'd10,
      OP_CPL  = 5'd11,
      OP_SCF  = 5'd12,
      OP_CCF  = 5'd13,
      OP_RLCA = 5'd14,
      OP_RRCA = 5'd15,
      OP_RLA  = 5'd16,
      OP_RRA  = 5'd17,
      OP_RLC  = 5'd18,
      OP_RRC  = 5'd19,
      OP_RL   = 5'd20,
      OP_RR   = 5'd21,
      OP_SLA  = 5'd22,
      OP_SRA  = 5'd23,
      OP_SRL  = 5'd24,
      OP_SWAP = 5'd25,
      OP_BIT  = 5'd26,
      OP_RES  = 5'd27,
      OP_SET  = 5'd28
   } op_type;

   // packed as z bit3, n bit2, h bit1, c bit0
   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [OpWidth-1:0]     op;
      logic [DataWidth-1:0]   a;
      logic [DataWidth-1:0]   b;
      logic [BitIdxWidth-1:0] bit_idx;
      flags_type              flags;
   } alu_req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result;
      flags_type            flags;
      logic                 write_back;
   } alu_rsp_type;

endpackage

// ----- rtl/sm83_alu_core.sv -----
// sm83_alu_core: combinational byte alu, one operation from operands and flags
// depends on sm83_pkg
`timescale 1ns / 1ps

module sm83_alu_core
   import sm83_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [DataWidth-1:0] a;
   logic [DataWidth-1:0] b;
   logic                 cin;
   logic                 use_carry;
   logic [DataWidth:0]   sum9;
   logic [4:0]           half_sum;
   logic [DataWidth:0]   diff9;
   logic [4:0]           half_diff;
   logic                 daa_lo;
   logic                 daa_hi;
   logic [DataWidth-1:0] daa_corr;
   logic [DataWidth-1:0] daa_res;
   logic [DataWidth-1:0] bit_mask;
   logic [DataWidth-1:0] r;
   flags_type            f;
   logic                 wb;

   assign a   = req.a;
   assign b   = req.b;
   assign cin = req.flags.c;

   assign use_carry = (req.op == OP_ADC) || (req.op == OP_SBC);

   // shared adder and subtractor, carry in only for adc / sbc
   assign sum9      = {1'b0, a} + {1'b0, b} + {{DataWidth{1'b0}}, use_carry & cin};
   assign half_sum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, use_carry & cin};
   assign diff9     = {1'b0, a} - {1'b0, b} - {{DataWidth{1'b0}}, use_carry & cin};
   assign half_diff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, use_carry & cin};

   // decimal adjust: both corrections decided on the unadjusted byte
   assign daa_lo   = req.flags.n ? req.flags.h : (req.flags.h || (a[3:0] > BcdLowMax));
   assign daa_hi   = req.flags.n ? cin : (cin || (a > BcdByteMax));
   assign daa_corr = {(daa_hi ? BcdCorr : 4'h0), (daa_lo ? BcdCorr : 4'h0)};
   assign daa_res  = req.flags.n ? (a - daa_corr) : (a + daa_corr);

   assign bit_mask = DataWidth'(1) << req.bit_idx;

   always_comb begin
      r  = a;
      f  = req.flags;
      wb = 1'b1;
      case (req.op)
         OP_ADD, OP_ADC: begin
            r = sum9[DataWidth-1:0];
            f = '{z: (sum9[DataWidth-1:0] == '0), n: 1'b0, h: half_sum[4], c: sum9[DataWidth]};
         end
         OP_SUB, OP_SBC: begin
            r = diff9[DataWidth-1:0];
            f = '{z: (diff9[DataWidth-1:0] == '0), n: 1'b1, h: half_diff[4],
                  c: diff9[DataWidth]};
         end
         OP_CP: begin
            wb = 1'b0;
            f  = '{z: (diff9[DataWidth-1:0] == '0), n: 1'b1, h: half_diff[4],
                   c: diff9[DataWidth]};
         end
         OP_AND: begin
            r = a & b;
            f = '{z: ((a & b) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         OP_XOR: begin
            r = a ^ b;
            f = '{z: ((a ^ b) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_OR: begin
            r = a | b;
            f = '{z: ((a | b) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_INC: begin
            r = a + 8'd1;
            f = '{z: (a == 8'hFF), n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
         end
         OP_DEC: begin
            r = a - 8'd1;
            f = '{z: (a == 8'h01), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
         end
         OP_DAA: begin
            r = daa_res;
            f = '{z: (daa_res == '0), n: req.flags.n, h: 1'b0, c: daa_hi};
         end
         OP_CPL: begin
            r = ~a;
            f = '{z: req.flags.z, n: 1'b1, h: 1'b1, c: cin};
         end
         OP_SCF: begin
            wb = 1'b0;
            f  = '{z: req.flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
         end
         OP_CCF: begin
            wb = 1'b0;
            f  = '{z: req.flags.z, n: 1'b0, h: 1'b0, c: ~cin};
         end
         // accumulator rotates always clear z
         OP_RLCA: begin
            r = {a[6:0], a[7]};
            f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
         end
         OP_RRCA: begin
            r = {a[0], a[7:1]};
            f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
         end
         OP_RLA: begin
            r = {a[6:0], cin};
            f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
         end
         OP_RRA: begin
            r = {cin, a[7:1]};
            f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
         end
         OP_RLC: begin
            r = {a[6:0], a[7]};
            f = '{z: (a == '0), n: 1'b0, h: 1'b0, c: a[7]};
         end
         OP_RRC: begin
            r = {a[0], a[7:1]};
            f = '{z: (a == '0), n: 1'b0, h: 1'b0, c: a[0]};
         end
         OP_RL: begin
            r = {a[6:0], cin};
            f = '{z: ({a[6:0], cin} == '0), n: 1'b0, h: 1'b0, c: a[7]};
         end
         OP_RR: begin
            r = {cin, a[7:1]};
            f = '{z: ({cin, a[7:1]} == '0), n: 1'b0, h: 1'b0, c: a[0]};
         end
         OP_SLA: begin
            r = {a[6:0], 1'b0};
            f = '{z: (a[6:0] == '0), n: 1'b0, h: 1'b0, c: a[7]};
         end
         OP_SRA: begin
            r = {a[7], a[7:1]};
            f = '{z: (a[7:1] == '0), n: 1'b0, h: 1'b0, c: a[0]};
         end
         OP_SRL: begin
            r = {1'b0, a[7:1]};
            f = '{z: (a[7:1] == '0), n: 1'b0, h: 1'b0, c: a[0]};
         end
         OP_SWAP: begin
            r = {a[3:0], a[7:4]};
            f = '{z: (a == '0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_BIT: begin
            wb = 1'b0;
            f  = '{z: ((a & bit_mask) == '0), n: 1'b0, h: 1'b1, c: cin};
         end
         OP_RES: begin
            r = a & ~bit_mask;
         end
         OP_SET: begin
            r = a | bit_mask;
         end
         default: begin
            // unused codes: no operation
            wb = 1'b0;
         end
      endcase
   end

   assign rsp = '{result: r, flags: f, write_back: wb};

endmodule

// ----- rtl/sm83_alu_with_flags.sv -----
// sm83_alu_with_flags: top level of the sm83 byte alu with request and response registers
// depends on sm83_pkg and sm83_alu_core
`timescale 1ns / 1ps

//  channel   | direction | ports                                       | transfer
//  ----------+-----------+---------------------------------------------+---------------------
//  request   | in        | req_type, req_operand_a/_b, req_bit_index,  | start high, busy low
//            |           | req_flags_in                                |
//  response  | out       | rsp_result, rsp_flags_out, rsp_write_back   | rsp_strobe high
//
//  one operation per cycle; busy stays low so a request can arrive every cycle
//  each request passes the request register, then alu logic into the response register
//  the response is shown for one cycle only; the receiver takes it without a handshake
//  synchronous reset clears both valid bits; payload registers are not reset

module sm83_alu_with_flags
   import sm83_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [OpWidth-1:0]     req_type,
   input  logic [DataWidth-1:0]   req_operand_a,
   input  logic [DataWidth-1:0]   req_operand_b,
   input  logic [BitIdxWidth-1:0] req_bit_index,
   input  logic [FlagWidth-1:0]   req_flags_in,
   output logic                   rsp_strobe,
   output logic [DataWidth-1:0]   rsp_result,
   output logic [FlagWidth-1:0]   rsp_flags_out,
   output logic                   rsp_write_back
);

   logic        req_valid_ff;
   logic        req_valid_in;
   alu_req_type req_ff;
   alu_req_type req_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   alu_rsp_type rsp_ff;
   alu_rsp_type rsp_in;

   // no kept state and no multi-cycle unit, so nothing ever holds off a request
   assign busy = 1'b0;

   // request transfer
   assign req_valid_in = start & ~busy;
   assign req_in = '{op:      req_type,
                     a:       req_operand_a,
                     b:       req_operand_b,
                     bit_idx: req_bit_index,
                     flags:   flags_type'(req_flags_in)};

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   // payload only matters while its valid bit is set
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
   end

   // single pass of alu logic between the two registers
   sm83_alu_core u_core (
      .req (req_ff),
      .rsp (rsp_in)
   );

   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   // response transfer, a one-cycle strobe per result
   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_result     = rsp_ff.result;
   assign rsp_flags_out  = rsp_ff.flags;
   assign rsp_write_back = rsp_ff.write_back;

endmodule

// ----- rtl/sm83_alu_chk.sv -----
// sm83_alu_chk: port-level checks on the sm83 alu, bound to the top level
// depends on sm83_pkg and sm83_alu_with_flags
`timescale 1ns / 1ps

module sm83_alu_chk
   import sm83_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic [OpWidth-1:0]     req_type,
   input logic [DataWidth-1:0]   req_operand_a,
   input logic [FlagWidth-1:0]   req_flags_in,
   input logic                   rsp_strobe,
   input logic [DataWidth-1:0]   rsp_result,
   input logic [FlagWidth-1:0]   rsp_flags_out,
   input logic                   rsp_write_back
);

   // every request transfer gives a response through the request and response registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("response missing after request transfer");

   // no response without an earlier request transfer through both registers
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> ##1 !rsp_strobe)
      else $error("response without request");

   // compare keeps the accumulator and does not write back
   a_cp_no_write: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == OP_CP) |=> ##1
         (!rsp_write_back && rsp_result == $past(req_operand_a, 2)))
      else $error("compare changed the result or wrote back");

   // bit reset and set leave the flags untouched
   a_res_set_flags: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == OP_RES || req_type == OP_SET)) |=> ##1
         (rsp_write_back && rsp_flags_out == $past(req_flags_in, 2)))
      else $error("res or set altered the flags");

endmodule

bind sm83_alu_with_flags sm83_alu_chk u_sm83_alu_chk (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_type       (req_type),
   .req_operand_a  (req_operand_a),
   .req_flags_in   (req_flags_in),
   .rsp_strobe     (rsp_strobe),
   .rsp_result     (rsp_result),
   .rsp_flags_out  (rsp_flags_out),
   .rsp_write_back (rsp_write_back)
);
